// ===== hw/rtl/qtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtd_pkg: shared types and constants of the quadtree image decoder
// Field widths, stream codes, byte phase encoding and the result record.
// ----------------------------------------------------------------------------
package qtd_pkg;

    localparam int MAX_LOG2_SIDE_DEF = 10;

    localparam int BYTE_W  = 8;
    localparam int LOG2_W  = 4;
    localparam int POS_W   = 10;
    localparam int SIDE_W  = 11;
    localparam int COLOR_W = 8;

    localparam logic [LOG2_W-1:0] LOG2_SIDE_RESET = 4'd8;

    localparam logic [BYTE_W-1:0] CODE_LEAF  = 8'd0;
    localparam logic [BYTE_W-1:0] CODE_SPLIT = 8'd1;

    localparam logic [1:0] QUAD_LAST = 2'd3;

    localparam logic ST_FILL    = 1'b0;
    localparam logic ST_CORRUPT = 1'b1;

    typedef enum logic [2:0] {
        PH_CODE  = 3'd0,
        PH_RED   = 3'd1,
        PH_GREEN = 3'd2,
        PH_BLUE  = 3'd3,
        PH_ALPHA = 3'd4
    } t_phase;

    typedef struct packed {
        logic [POS_W-1:0]   x_pos;
        logic [POS_W-1:0]   y_pos;
        logic [SIDE_W-1:0]  side_len;
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic               status;
        logic               image_done;
    } t_result;

endpackage

// ===== hw/rtl/quadtree_image_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_image_decoder_core: quadtree image stream decoder
// Turns a coded quadtree byte stream into square fill commands.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per transaction (i_in_valid / o_in_stall).
// Output channel: one fill command or error report per transaction
// (o_out_valid / i_out_stall). A leaf gives its command on its alpha byte;
// valid code bytes and red, green and blue bytes give nothing. A bad code
// byte and every byte after it give an error report until reset.
// A byte is taken into the input register and decoded from there into the
// result register. Throughput: one byte per cycle while the receiver does
// not stall, set by the single decode stage between the two registers.
// i_cfg_we writes log2 of the image side (i_cfg_wdata) and restarts the
// image; write it only while no transaction is in flight.
// Reset (i_rst_n low, synchronous) empties both registers, sets log2 side
// to 8, returns to the tree root and clears the corruption flag.
// While the receiver stalls, the result holds; the byte behind it waits in
// the input register and further input is stalled.
// ----------------------------------------------------------------------------
module quadtree_image_decoder_core #(
    parameter int MAX_LOG2_SIDE = qtd_pkg::MAX_LOG2_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [qtd_pkg::LOG2_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [qtd_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [qtd_pkg::POS_W-1:0]    o_x_pos,
    output logic [qtd_pkg::POS_W-1:0]    o_y_pos,
    output logic [qtd_pkg::SIDE_W-1:0]   o_side_len,
    output logic [qtd_pkg::COLOR_W-1:0]  o_red_out,
    output logic [qtd_pkg::COLOR_W-1:0]  o_green_out,
    output logic [qtd_pkg::COLOR_W-1:0]  o_blue_out,
    output logic                         o_status,
    output logic                         o_image_done
);

    logic                        r_in_valid;
    logic [qtd_pkg::BYTE_W-1:0]  r_in_byte;
    logic                        r_out_valid;
    qtd_pkg::t_result            r_out;

    logic             w_out_free;
    logic             w_step;
    logic             w_res_valid;
    qtd_pkg::t_result w_res;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    qtd_tree_walk #(
        .MAX_LOG2_SIDE (MAX_LOG2_SIDE)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    // Hold the result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_x_pos      = r_out.x_pos;
    assign o_y_pos      = r_out.y_pos;
    assign o_side_len   = r_out.side_len;
    assign o_red_out    = r_out.red_out;
    assign o_green_out  = r_out.green_out;
    assign o_blue_out   = r_out.blue_out;
    assign o_status     = r_out.status;
    assign o_image_done = r_out.image_done;

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted byte lost from input register");

    a_step_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |-> w_step)
        else $error("pending byte not decoded while result register empty");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !$past(r_out_valid) && !$past(r_in_valid)) |-> !o_out_valid)
        else $error("result appeared without a decoded byte");

endmodule

// ===== hw/rtl/qtd_tree_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtd_tree_walk: quadtree walk state and per-byte decode
// Holds byte phase, tree level, quadrant path, held colour and the sticky
// corruption flag; decodes one stream byte per step into an optional result.
// ----------------------------------------------------------------------------
module qtd_tree_walk #(
    parameter int MAX_LOG2_SIDE = qtd_pkg::MAX_LOG2_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [qtd_pkg::LOG2_W-1:0]  i_cfg_wdata,
    input  logic                        i_step,
    input  logic [qtd_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_res_valid,
    output qtd_pkg::t_result            o_res
);

    localparam int LVW = $clog2(MAX_LOG2_SIDE + 1);
    localparam int PIW = (MAX_LOG2_SIDE > 1) ? $clog2(MAX_LOG2_SIDE) : 1;
    localparam int XW  = (MAX_LOG2_SIDE > qtd_pkg::POS_W) ? MAX_LOG2_SIDE : qtd_pkg::POS_W;
    localparam int SW  = (MAX_LOG2_SIDE + 1 > qtd_pkg::SIDE_W) ?
                         MAX_LOG2_SIDE + 1 : qtd_pkg::SIDE_W;

    logic [qtd_pkg::LOG2_W-1:0]  r_log2, n_log2;
    qtd_pkg::t_phase             r_phase, n_phase;
    logic [LVW-1:0]              r_level, n_level;
    logic [1:0]                  r_path [MAX_LOG2_SIDE];
    logic [1:0]                  n_path [MAX_LOG2_SIDE];
    logic [qtd_pkg::COLOR_W-1:0] r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic                        r_corrupt, n_corrupt;

    logic [LVW-1:0]           w_eff;
    logic [LVW-1:0]           w_lv;
    logic [MAX_LOG2_SIDE-1:0] w_xf, w_yf;
    logic [XW-1:0]            w_x, w_y;
    logic [SW-1:0]            w_side;
    logic [PIW-1:0]           w_found;
    logic                     w_any;
    logic                     w_split_ok;

    // Register values above the supported depth act as the maximum.
    assign w_eff = (r_log2 > qtd_pkg::LOG2_W'(MAX_LOG2_SIDE)) ?
                   LVW'(MAX_LOG2_SIDE) : LVW'(r_log2);
    assign w_lv  = (r_level > w_eff) ? w_eff : r_level;
    assign w_split_ok = (r_level < w_eff);

    // Leaf origin: quadrant at depth i lands on bit (eff-1-i).
    always_comb begin
        for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
            w_xf[MAX_LOG2_SIDE-1-i] = (LVW'(i) < w_lv) && r_path[i][0];
            w_yf[MAX_LOG2_SIDE-1-i] = (LVW'(i) < w_lv) && r_path[i][1];
        end
    end

    assign w_x    = XW'(w_xf) >> (LVW'(MAX_LOG2_SIDE) - w_eff);
    assign w_y    = XW'(w_yf) >> (LVW'(MAX_LOG2_SIDE) - w_eff);
    assign w_side = SW'(1) << (w_eff - w_lv);

    // Ascent: deepest open level whose quadrant is not the last one.
    always_comb begin
        w_any   = 1'b0;
        w_found = '0;
        for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
            if ((LVW'(i) < r_level) && (r_path[i] != qtd_pkg::QUAD_LAST)) begin
                w_any   = 1'b1;
                w_found = PIW'(i);
            end
        end
    end

    // Next byte phase
    always_comb begin
        n_phase = r_phase;
        if (i_cfg_we) begin
            n_phase = qtd_pkg::PH_CODE;
        end else if (i_step && !r_corrupt) begin
            unique case (r_phase)
                qtd_pkg::PH_RED:   n_phase = qtd_pkg::PH_GREEN;
                qtd_pkg::PH_GREEN: n_phase = qtd_pkg::PH_BLUE;
                qtd_pkg::PH_BLUE:  n_phase = qtd_pkg::PH_ALPHA;
                qtd_pkg::PH_ALPHA: n_phase = qtd_pkg::PH_CODE;
                default: begin
                    n_phase = (i_byte == qtd_pkg::CODE_LEAF) ?
                              qtd_pkg::PH_RED : qtd_pkg::PH_CODE;
                end
            endcase
        end
    end

    // Datapath, tree state and result
    always_comb begin
        n_log2      = r_log2;
        n_level     = r_level;
        n_path      = r_path;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_corrupt   = r_corrupt;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_cfg_we) begin
            // Abandon the image in progress.
            n_log2  = i_cfg_wdata;
            n_level = '0;
            for (int i = 0; i < MAX_LOG2_SIDE; i++) n_path[i] = '0;
        end else if (i_step) begin
            if (r_corrupt) begin
                o_res_valid  = 1'b1;
                o_res.status = qtd_pkg::ST_CORRUPT;
            end else begin
                unique case (r_phase)
                    qtd_pkg::PH_RED:   n_red   = i_byte;
                    qtd_pkg::PH_GREEN: n_green = i_byte;
                    qtd_pkg::PH_BLUE:  n_blue  = i_byte;
                    qtd_pkg::PH_ALPHA: begin
                        o_res_valid      = 1'b1;
                        o_res.x_pos      = w_x[qtd_pkg::POS_W-1:0];
                        o_res.y_pos      = w_y[qtd_pkg::POS_W-1:0];
                        o_res.side_len   = w_side[qtd_pkg::SIDE_W-1:0];
                        o_res.red_out    = r_red;
                        o_res.green_out  = r_green;
                        o_res.blue_out   = r_blue;
                        o_res.status     = qtd_pkg::ST_FILL;
                        o_res.image_done = !w_any;
                        if (w_any) begin
                            n_path[w_found] = r_path[w_found] + 2'd1;
                            n_level         = LVW'(w_found) + LVW'(1);
                        end else begin
                            n_level = '0;
                            for (int i = 0; i < MAX_LOG2_SIDE; i++) n_path[i] = '0;
                        end
                    end
                    default: begin
                        if (i_byte == qtd_pkg::CODE_LEAF) begin
                            n_corrupt = 1'b0;
                        end else if ((i_byte == qtd_pkg::CODE_SPLIT) && w_split_ok) begin
                            n_path[r_level[PIW-1:0]] = '0;
                            n_level = r_level + LVW'(1);
                        end else begin
                            n_corrupt    = 1'b1;
                            o_res_valid  = 1'b1;
                            o_res.status = qtd_pkg::ST_CORRUPT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2    <= qtd_pkg::LOG2_SIDE_RESET;
            r_phase   <= qtd_pkg::PH_CODE;
            r_level   <= '0;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
            r_corrupt <= 1'b0;
            for (int i = 0; i < MAX_LOG2_SIDE; i++) r_path[i] <= '0;
        end else begin
            r_log2    <= n_log2;
            r_phase   <= n_phase;
            r_level   <= n_level;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_corrupt <= n_corrupt;
            r_path    <= n_path;
        end
    end

    a_corrupt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_corrupt |=> r_corrupt)
        else $error("corruption flag cleared without reset");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= w_eff)
        else $error("tree level deeper than image allows");

    a_corrupt_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg_we && r_corrupt) |-> (o_res_valid && o_res.status))
        else $error("byte in corrupt state gave no error result");

    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.image_done && !i_cfg_we) |=> (r_level == '0))
        else $error("finished image did not return to root");

endmodule
